[src/tsb_pkg.sv]
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants for the software timer bank
// Timer entry layout, action and result codes, sequencer states.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int STEP_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int INTERVAL_W = 24;
  localparam int REMAIN_W   = 25;
  localparam int HANDLE_W   = 16;
  localparam int ELAPSED_W  = 16;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    KIND_CREATED   = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_REMOVED   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_DONE      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_REPORT
  } seq_state_t;

  typedef struct packed {
    logic                        live;
    logic                        once;
    logic signed [REMAIN_W-1:0]  remain;
    logic [INTERVAL_W-1:0]       reload;
    logic [HANDLE_W-1:0]         handle;
  } entry_t;

endpackage

[src/software_timer_bank.sv]
// ----------------------------------------------------------------------------
// software_timer_bank: pool of one-shot and periodic countdown timers
// Every create, remove or tick item takes one full sweep of the bank: the ring
// of 16 timer slots rotates once past the head update logic, one slot per
// cycle, then a report state forms the final result, which sits on the result
// ports in the cycle after that. start is taken again in that report state,
// so items can follow back to back and the final result of one item overlaps
// the first sweep cycle of the next. Expiries are reported in slot order,
// each in the cycle after its slot passes the head, then the tick-done result
// with last set. Results are strobed for one cycle and cannot be held off.
// An action code of 3 is not accepted and gives no result.
// ----------------------------------------------------------------------------
module software_timer_bank (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [tsb_pkg::INTERVAL_W-1:0] interval_ms,
  input  logic                          single_fire,
  input  logic [tsb_pkg::HANDLE_W-1:0]   target_handle,
  input  logic [tsb_pkg::ELAPSED_W-1:0]  elapsed_ms,
  output logic                          strobe,
  output logic [2:0]                    kind,
  output logic [tsb_pkg::HANDLE_W-1:0]   handle_out,
  output logic                          last
);
  import tsb_pkg::*;

  entry_t ring [NUM_TIMERS];
  entry_t tail;
  logic   shift;

  // slot 0 sits at the head; the updated head entry re-enters at the tail
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ring
    entry_t din;
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign din = tail;
    end else begin : g_mid
      assign din = ring[i+1];
    end
    tsb_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   (din),
      .dout  (ring[i])
    );
  end

  tsb_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .interval_ms   (interval_ms),
    .single_fire   (single_fire),
    .target_handle (target_handle),
    .elapsed_ms    (elapsed_ms),
    .head          (ring[0]),
    .tail          (tail),
    .shift         (shift),
    .busy          (busy),
    .strobe        (strobe),
    .kind          (kind),
    .handle_out    (handle_out),
    .last          (last)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_CREATE || action == ACT_REMOVE ||
     action == ACT_TICK)) |=> busy)
    else $error("accepted item did not start a sweep");

  a_shift_busy: assert property (@(posedge clk) disable iff (rst)
    shift |-> busy)
    else $error("ring shifted outside a sweep");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last == (kind != KIND_EXPIRED)))
    else $error("last flag does not match result kind");

  a_expiry_tick: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == KIND_EXPIRED) |-> $past(busy))
    else $error("expiry reported outside a tick sweep");

endmodule

[src/tsb_cell.sv]
// ----------------------------------------------------------------------------
// tsb_cell: one timer slot of the ring
// Holds a timer entry and takes its neighbor's entry whenever the ring shifts.
// ----------------------------------------------------------------------------
module tsb_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  tsb_pkg::entry_t din,
  output tsb_pkg::entry_t dout
);
  import tsb_pkg::*;

  entry_t slot;

  // only the live bit is control state; the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.live <= 1'b0;
    end else if (shift) begin
      slot <= din;
    end
  end

  assign dout = slot;

endmodule

[src/tsb_seq.sv]
// ----------------------------------------------------------------------------
// tsb_seq: sweep sequencer and head-of-ring update
// Rotates the ring once per item, updates the slot passing the head and
// drives the registered result port.
// ----------------------------------------------------------------------------
module tsb_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    action,
  input  logic [tsb_pkg::INTERVAL_W-1:0] interval_ms,
  input  logic                          single_fire,
  input  logic [tsb_pkg::HANDLE_W-1:0]   target_handle,
  input  logic [tsb_pkg::ELAPSED_W-1:0]  elapsed_ms,
  input  tsb_pkg::entry_t               head,
  output tsb_pkg::entry_t               tail,
  output logic                          shift,
  output logic                          busy,
  output logic                          strobe,
  output logic [2:0]                    kind,
  output logic [tsb_pkg::HANDLE_W-1:0]   handle_out,
  output logic                          last
);
  import tsb_pkg::*;

  seq_state_t             state, state_next;
  logic [STEP_W-1:0]      step;
  action_t                op;
  logic [INTERVAL_W-1:0]  interval_r;
  logic                   once_r;
  logic [HANDLE_W-1:0]    target_r;
  logic [ELAPSED_W-1:0]   elapsed_r;
  logic                   found, found_next;
  logic [HANDLE_W-1:0]    counter;
  logic                   load;
  logic                   act_ok;
  logic                   last_step;
  logic signed [REMAIN_W-1:0] remain_sub;

  logic                   strobe_next;
  kind_t                  kind_next;
  logic [HANDLE_W-1:0]    handle_next;
  logic                   last_next;

  assign busy      = (state == S_SWEEP);
  assign act_ok    = (action == ACT_CREATE) || (action == ACT_REMOVE) ||
                     (action == ACT_TICK);
  assign load      = start && !busy && act_ok;
  assign last_step = (step == STEP_W'(NUM_TIMERS - 1));
  assign remain_sub = head.remain -
                      $signed({{(REMAIN_W - ELAPSED_W){1'b0}}, elapsed_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      found   <= 1'b0;
      counter <= '0;
      strobe  <= 1'b0;
      op      <= ACT_CREATE;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (state == S_REPORT && op == ACT_CREATE && found) begin
        counter <= counter + 1'b1;
      end
      if (load) begin
        op    <= action_t'(action);
        step  <= '0;
        found <= 1'b0;
      end else begin
        found <= found_next;
        if (shift) begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      interval_r <= interval_ms;
      once_r     <= single_fire;
      target_r   <= target_handle;
      elapsed_r  <= elapsed_ms;
    end
    kind       <= kind_next;
    handle_out <= handle_next;
    last       <= last_next;
  end

  always_comb begin
    state_next  = state;
    shift       = 1'b0;
    tail        = head;
    found_next  = found;
    strobe_next = 1'b0;
    kind_next   = KIND_DONE;
    handle_next = '0;
    last_next   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (load) state_next = S_SWEEP;
      end

      S_SWEEP: begin
        shift = 1'b1;
        case (op)
          ACT_CREATE: begin
            if (!found && !head.live) begin
              tail.live   = 1'b1;
              tail.once   = once_r;
              tail.remain = $signed({1'b0, interval_r});
              tail.reload = interval_r;
              tail.handle = counter;
              found_next  = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (!found && head.live && head.handle == target_r) begin
              tail.live  = 1'b0;
              found_next = 1'b1;
            end
          end
          default: begin
            if (head.live) begin
              if (remain_sub < 0) begin
                strobe_next = 1'b1;
                kind_next   = KIND_EXPIRED;
                handle_next = head.handle;
                if (head.once) tail.live = 1'b0;
                else           tail.remain = $signed({1'b0, head.reload});
              end else begin
                tail.remain = remain_sub;
              end
            end
          end
        endcase
        if (last_step) state_next = S_REPORT;
      end

      S_REPORT: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        case (op)
          ACT_CREATE: begin
            kind_next   = found ? KIND_CREATED : KIND_FULL;
            handle_next = found ? counter : '0;
          end
          ACT_REMOVE: begin
            kind_next   = found ? KIND_REMOVED : KIND_NOT_FOUND;
            handle_next = target_r;
          end
          default: begin
            kind_next   = KIND_DONE;
            handle_next = '0;
          end
        endcase
        state_next = load ? S_SWEEP : S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
